// File: hw/rtl/rdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ring deque with duration tally.
// Used by rdt_acc, ring_deque_with_duration_tally and tb_top; depends on nothing.
package rdt_pkg;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned TEMPO_W  = 9;
	localparam int unsigned MIN_IN_W = 8;
	localparam int unsigned SEC_W    = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LIVE_W   = 5;
	localparam int unsigned MIN_W    = 16;

	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TALLY      = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic [TEMPO_W-1:0] THR_RESET   = 9'd120;
	localparam logic [6:0]         SEC_PER_MIN = 7'd60;
	localparam logic [6:0]         SEC_TWO_MIN = 7'd120;
	localparam logic [MIN_W-1:0]   MIN_SAT     = 16'hFFFF;

	typedef struct packed {
		logic [TEMPO_W-1:0]  tempo;
		logic [MIN_IN_W-1:0] mins;
		logic [SEC_W-1:0]    secs;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic add;
	} acc_ctl_t;

endpackage

// File: hw/rtl/ring_deque_with_duration_tally.sv
`timescale 1ns / 1ps
// Ring deque with duration tally: top level, entry memory and sequencer.
// Push and pop are done in the cycle a beat is accepted; the result is registered
// and offered in the next cycle, so pushes and pops sustain one beat per cycle while
// the result channel is not stalled. A tally reads one live entry per cycle through the
// registered read port and stalls the input until its result is loaded.
// Reset clears indices, count and threshold (120); the entry memory is not cleared.
module ring_deque_with_duration_tally
	import rdt_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [TEMPO_W-1:0]  tempo,
	input  logic [MIN_IN_W-1:0] minutes,
	input  logic [SEC_W-1:0]    seconds,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [LIVE_W-1:0]   live_count,
	output logic [MIN_W-1:0]    total_min,
	output logic [SEC_W-1:0]    total_sec,
	output logic [MIN_W-1:0]    fast_min,
	output logic [SEC_W-1:0]    fast_sec,
	output logic [MIN_W-1:0]    slow_min,
	output logic [SEC_W-1:0]    slow_sec
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic          ADDR_THR = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t              state_q;
	logic [TEMPO_W-1:0]  thr_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       rd_addr_q;
	logic [CW-1:0]       rd_left_q;
	logic                rd_vld_s1;
	entry_t              rd_data_s1;
	entry_t              mem [DEPTH];

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [LIVE_W-1:0]   live_q;
	logic [MIN_W-1:0]    total_min_q;
	logic [SEC_W-1:0]    total_sec_q;
	logic [MIN_W-1:0]    fast_min_q;
	logic [SEC_W-1:0]    fast_sec_q;
	logic [MIN_W-1:0]    slow_min_q;
	logic [SEC_W-1:0]    slow_sec_q;

	logic                out_free;
	logic                req_acc;
	logic                cfg_wr;
	logic                is_full;
	logic                is_empty;
	logic [AW-1:0]       head_inc;
	logic [AW-1:0]       head_dec;
	logic [AW-1:0]       tail_inc;
	logic [AW-1:0]       tail_dec;
	logic [AW-1:0]       head_d;
	logic [AW-1:0]       tail_d;
	logic [CW-1:0]       cnt_d;
	logic [STATUS_W-1:0] status_d;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic                tally_go;
	logic                rd_issue;
	logic                walk_done;
	logic [CW+4:0]       cnt_wide;
	logic                is_fast;
	acc_ctl_t            ctl_all;
	acc_ctl_t            ctl_fast;
	acc_ctl_t            ctl_slow;
	entry_t              wr_ent;
	logic [MIN_W-1:0]    a_min;
	logic [SEC_W-1:0]    a_sec;
	logic [MIN_W-1:0]    f_min;
	logic [SEC_W-1:0]    f_sec;
	logic [MIN_W-1:0]    s_min;
	logic [SEC_W-1:0]    s_sec;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ADDR_THR) ? {{(32-TEMPO_W){1'b0}}, thr_q} : '0;

	// Handshakes.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign req_acc   = req_valid && !req_stall;

	assign is_full  = (cnt_q == CNT_FULL);
	assign is_empty = (cnt_q == '0);
	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		status_d = STAT_OK;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		tally_go = 1'b0;
		case (action)
			ACT_PUSH_BACK: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en   = req_acc;
					wr_addr = tail_q;
					tail_d  = tail_inc;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ACT_PUSH_FRONT: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en   = req_acc;
					wr_addr = head_dec;
					head_d  = head_dec;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (is_empty) begin
					status_d = STAT_EMPTY;
				end else begin
					head_d = head_inc;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (is_empty) begin
					status_d = STAT_EMPTY;
				end else begin
					tail_d = tail_dec;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			ACT_TALLY: begin
				tally_go = req_acc;
			end
			default: begin
			end
		endcase
	end

	// Held count shown to the user is the low five bits.
	assign cnt_wide = {5'b0, cnt_d};

	// Entry memory: one write port for pushes, one registered read port for the walk.
	assign wr_ent = '{tempo: tempo, mins: minutes, secs: seconds};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
	end

	assign rd_issue  = (state_q == ST_WALK) && (rd_left_q != '0);
	assign walk_done = (state_q == ST_WALK) && (rd_left_q == '0) && !rd_vld_s1;

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	// Tally accumulators.
	assign is_fast       = (rd_data_s1.tempo >= thr_q);
	assign ctl_all.clr   = tally_go;
	assign ctl_all.add   = rd_vld_s1;
	assign ctl_fast.clr  = tally_go;
	assign ctl_fast.add  = rd_vld_s1 && is_fast;
	assign ctl_slow.clr  = tally_go;
	assign ctl_slow.add  = rd_vld_s1 && !is_fast;

	rdt_acc u_acc_all (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_all),
		.mins    (rd_data_s1.mins),
		.secs    (rd_data_s1.secs),
		.sum_min (a_min),
		.sum_sec (a_sec)
	);

	rdt_acc u_acc_fast (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_fast),
		.mins    (rd_data_s1.mins),
		.secs    (rd_data_s1.secs),
		.sum_min (f_min),
		.sum_sec (f_sec)
	);

	rdt_acc u_acc_slow (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_slow),
		.mins    (rd_data_s1.mins),
		.secs    (rd_data_s1.secs),
		.sum_min (s_min),
		.sum_sec (s_sec)
	);

	// Sequencer, deque indices and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			rd_addr_q   <= '0;
			rd_left_q   <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			live_q      <= '0;
			total_min_q <= '0;
			total_sec_q <= '0;
			fast_min_q  <= '0;
			fast_sec_q  <= '0;
			slow_min_q  <= '0;
			slow_sec_q  <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == ADDR_THR)) begin
				thr_q <= pwdata[TEMPO_W-1:0];
			end
			rd_vld_s1 <= rd_issue;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (tally_go) begin
							state_q   <= ST_WALK;
							rd_addr_q <= head_q;
							rd_left_q <= cnt_q;
						end else begin
							head_q      <= head_d;
							tail_q      <= tail_d;
							cnt_q       <= cnt_d;
							rsp_valid_q <= 1'b1;
							status_q    <= status_d;
							live_q      <= cnt_wide[LIVE_W-1:0];
							total_min_q <= '0;
							total_sec_q <= '0;
							fast_min_q  <= '0;
							fast_sec_q  <= '0;
							slow_min_q  <= '0;
							slow_sec_q  <= '0;
						end
					end
				end
				ST_WALK: begin
					if (rd_issue) begin
						rd_addr_q <= (rd_addr_q == IDX_LAST) ? '0 : rd_addr_q + 1'b1;
						rd_left_q <= rd_left_q - 1'b1;
					end
					// The beat that started the walk left the result register
					// empty, so the tally can always be loaded here. The next beat
					// may already wait at the input, so the count comes from the
					// register and not from the decoded action.
					if (walk_done) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						status_q    <= STAT_OK;
						live_q      <= LIVE_W'(cnt_q);
						total_min_q <= a_min;
						total_sec_q <= a_sec;
						fast_min_q  <= f_min;
						fast_sec_q  <= f_sec;
						slow_min_q  <= s_min;
						slow_sec_q  <= s_sec;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign live_count = live_q;
	assign total_min  = total_min_q;
	assign total_sec  = total_sec_q;
	assign fast_min   = fast_min_q;
	assign fast_sec   = fast_sec_q;
	assign slow_min   = slow_min_q;
	assign slow_sec   = slow_sec_q;

	// Assertions.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("held count exceeds depth");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> !rsp_valid_q)
		else $error("tally finished while result register still occupied");

	a_no_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> req_stall)
		else $error("request accepted during tally walk");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_WALK) && $past(rd_issue))
		else $error("read data arrived outside a tally walk");

endmodule

// File: hw/rtl/rdt_acc.sv
`timescale 1ns / 1ps
// Duration accumulator: keeps a normalized minutes/seconds sum of entries.
// Depends on rdt_pkg.
module rdt_acc
	import rdt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  acc_ctl_t            ctl,
	input  logic [MIN_IN_W-1:0] mins,
	input  logic [SEC_W-1:0]    secs,
	output logic [MIN_W-1:0]    sum_min,
	output logic [SEC_W-1:0]    sum_sec
);

	logic [MIN_W-1:0] acc_min_q;
	logic [SEC_W-1:0] acc_sec_q;
	logic [6:0]       sec_sum;
	logic [1:0]       carry;
	logic [6:0]       sec_norm;
	logic [MIN_W:0]   min_sum;

	// The running seconds stay below 60 and an entry adds at most 63, so at
	// most two minutes carry out per entry.
	always_comb begin
		sec_sum = {1'b0, acc_sec_q} + {1'b0, secs};
		if (sec_sum >= SEC_TWO_MIN) begin
			carry    = 2'd2;
			sec_norm = sec_sum - SEC_TWO_MIN;
		end else if (sec_sum >= SEC_PER_MIN) begin
			carry    = 2'd1;
			sec_norm = sec_sum - SEC_PER_MIN;
		end else begin
			carry    = 2'd0;
			sec_norm = sec_sum;
		end
		min_sum = {1'b0, acc_min_q} + (MIN_W+1)'(mins) + (MIN_W+1)'(carry);
	end

	// The true minute count only grows, so saturating each partial sum gives
	// the same result as saturating the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_min_q <= '0;
			acc_sec_q <= '0;
		end else if (ctl.clr) begin
			acc_min_q <= '0;
			acc_sec_q <= '0;
		end else if (ctl.add) begin
			acc_min_q <= min_sum[MIN_W] ? MIN_SAT : min_sum[MIN_W-1:0];
			acc_sec_q <= sec_norm[SEC_W-1:0];
		end
	end

	assign sum_min = acc_min_q;
	assign sum_sec = acc_sec_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_deque_with_duration_tally: directed and random deque actions,
// with threshold changes over the APB port and random idling on both channels.
// Depends on rdt_pkg and the ring_deque_with_duration_tally RTL only.
module tb_top;
	import rdt_pkg::*;

	localparam int DEPTH         = 16;
	localparam int RANDOM_ITEMS  = 400;
	localparam int SEGMENT_ITEMS = 40;
	localparam int QUIET_LIMIT   = 5000;
	localparam int IDLE_PCT      = 26;

	localparam logic [2:0] REG_FAST_THR_ADDR = 3'd0;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LIVE_W-1:0]   live_count;
		logic [MIN_W-1:0]    total_min;
		logic [SEC_W-1:0]    total_sec;
		logic [MIN_W-1:0]    fast_min;
		logic [SEC_W-1:0]    fast_sec;
		logic [MIN_W-1:0]    slow_min;
		logic [SEC_W-1:0]    slow_sec;
	} deque_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [ACTION_W-1:0] action = '0;
	logic [TEMPO_W-1:0]  tempo = '0;
	logic [MIN_IN_W-1:0] minutes = '0;
	logic [SEC_W-1:0]    seconds = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [LIVE_W-1:0]   live_count;
	logic [MIN_W-1:0]    total_min;
	logic [SEC_W-1:0]    total_sec;
	logic [MIN_W-1:0]    fast_min;
	logic [SEC_W-1:0]    fast_sec;
	logic [MIN_W-1:0]    slow_min;
	logic [SEC_W-1:0]    slow_sec;

	// Shadow copy of the deque and its threshold.
	entry_t             shadow_ring [DEPTH];
	int                 shadow_head = 0;
	int                 shadow_tail = 0;
	int                 shadow_held = 0;
	logic [TEMPO_W-1:0] shadow_thr = THR_RESET;

	deque_result_t pending_results [$];

	bit calm = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int tallies_sent = 0;
	int refusals = 0;
	int thr_writes = 0;

	ring_deque_with_duration_tally #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.tempo      (tempo),
		.minutes    (minutes),
		.seconds    (seconds),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.live_count (live_count),
		.total_min  (total_min),
		.total_sec  (total_sec),
		.fast_min   (fast_min),
		.fast_sec   (fast_sec),
		.slow_min   (slow_min),
		.slow_sec   (slow_sec)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void split_seconds(input int unsigned sum_s, output logic [MIN_W-1:0] m,
		output logic [SEC_W-1:0] s);
		int unsigned whole;
		whole = sum_s / SEC_PER_MIN;
		m = (whole > MIN_SAT) ? MIN_SAT : MIN_W'(whole);
		s = SEC_W'(sum_s % SEC_PER_MIN);
	endfunction

	// Applies one action to the shadow deque and returns the result beat it should produce.
	function automatic deque_result_t apply_action(input logic [ACTION_W-1:0] act,
		input logic [TEMPO_W-1:0] tmp, input logic [MIN_IN_W-1:0] mn, input logic [SEC_W-1:0] sc);
		deque_result_t r;
		int unsigned all_s, fast_s, slow_s, dur;
		int idx;
		r = '0;
		r.status = STAT_OK;
		case (act)
		ACT_PUSH_BACK: begin
			if (shadow_held >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_ring[shadow_tail] = '{tempo: tmp, mins: mn, secs: sc};
				shadow_tail = (shadow_tail + 1) % DEPTH;
				shadow_held++;
			end
		end
		ACT_PUSH_FRONT: begin
			if (shadow_held >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
				shadow_ring[shadow_head] = '{tempo: tmp, mins: mn, secs: sc};
				shadow_held++;
			end
		end
		ACT_POP_FRONT: begin
			if (shadow_held == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				shadow_head = (shadow_head + 1) % DEPTH;
				shadow_held--;
			end
		end
		ACT_POP_BACK: begin
			if (shadow_held == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
				shadow_held--;
			end
		end
		ACT_TALLY: begin
			all_s = 0;
			fast_s = 0;
			slow_s = 0;
			idx = shadow_head;
			for (int n = 0; n < shadow_held; n++) begin
				dur = shadow_ring[idx].mins * SEC_PER_MIN + shadow_ring[idx].secs;
				all_s += dur;
				if (shadow_ring[idx].tempo >= shadow_thr)
					fast_s += dur;
				else
					slow_s += dur;
				idx = (idx + 1) % DEPTH;
			end
			split_seconds(all_s, r.total_min, r.total_sec);
			split_seconds(fast_s, r.fast_min, r.fast_sec);
			split_seconds(slow_s, r.slow_min, r.slow_sec);
		end
		default: ;
		endcase
		r.live_count = LIVE_W'(shadow_held);
		return r;
	endfunction

	// Offers one beat, holds it until accepted, then records what it should produce.
	// Handshake signals are sampled at the falling edge, where nothing changes.
	task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [TEMPO_W-1:0] tmp,
		input logic [MIN_IN_W-1:0] mn, input logic [SEC_W-1:0] sc);
		bit took;
		deque_result_t r;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		tempo <= tmp;
		minutes <= mn;
		seconds <= sc;
		do begin
			@(negedge clk);
			took = !req_stall;
			@(posedge clk);
		end while (!took);
		r = apply_action(act, tmp, mn, sc);
		pending_results.push_back(r);
		beats_sent++;
		if (act == ACT_TALLY)
			tallies_sent++;
		if (r.status != STAT_OK)
			refusals++;
	endtask

	task automatic send_random_beat(input int push_pct);
		logic [ACTION_W-1:0] act;
		logic [SEC_W-1:0] sc;
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			act = ACTION_W'($urandom_range(7, ACT_TALLY + 1));
		else if (pick < 16)
			act = ACT_TALLY;
		else if ($urandom_range(99) < push_pct)
			act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		else
			act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
		// Mostly legal seconds, sometimes values past 59 that must carry.
		sc = ($urandom_range(9) == 0) ? SEC_W'($urandom_range(63)) : SEC_W'($urandom_range(59));
		send_beat(act, TEMPO_W'($urandom_range(511)), MIN_IN_W'($urandom_range(255)), sc);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// A tally may still be walking the memory after its beat left.
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(negedge clk);
		while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_threshold_readback();
		logic [31:0] rd;
		apb_access(1'b0, REG_FAST_THR_ADDR, '0, rd);
		if (rd[TEMPO_W-1:0] !== shadow_thr) begin
			$error("fast_tempo_threshold readback expected %0d actual %0d", shadow_thr,
				rd[TEMPO_W-1:0]);
			errors++;
		end
	endtask

	task automatic set_threshold(input logic [TEMPO_W-1:0] thr);
		logic [31:0] unused_rd;
		wait_drained();
		apb_access(1'b1, REG_FAST_THR_ADDR, 32'(thr), unused_rd);
		shadow_thr = thr;
		thr_writes++;
		check_threshold_readback();
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk)
		rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Result beats are accepted at the next rising edge; compare them against the oldest expectation.
	always @(negedge clk) begin
		deque_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat arrived with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				beats_checked++;
				check_field("status", want.status, status);
				check_field("live_count", want.live_count, live_count);
				check_field("total_min", want.total_min, total_min);
				check_field("total_sec", want.total_sec, total_sec);
				check_field("fast_min", want.fast_min, fast_min);
				check_field("fast_sec", want.fast_sec, fast_sec);
				check_field("slow_min", want.slow_min, slow_min);
				check_field("slow_sec", want.slow_sec, slow_sec);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ring_deque_with_duration_tally: mismatch");
			$finish;
		end
	end

	task automatic test_empty_deque();
		send_beat(ACT_TALLY, '0, '0, '0);
		send_beat(ACT_POP_FRONT, '0, '0, '0);
		send_beat(ACT_POP_BACK, '1, '1, '1);
		for (int a = ACT_TALLY + 1; a < 8; a++)
			send_beat(ACTION_W'(a), TEMPO_W'($urandom_range(511)), '1, '0);
	endtask

	// Fills the deque from both ends with field extremes and tempos on either side of the
	// threshold, then pushes against the full deque and tallies it.
	task automatic test_fill_to_full();
		send_beat(ACT_PUSH_BACK, '1, '1, '1);
		send_beat(ACT_PUSH_FRONT, '0, '0, '0);
		send_beat(ACT_PUSH_BACK, THR_RESET, 8'd1, 6'd59);
		send_beat(ACT_PUSH_FRONT, THR_RESET - 9'd1, 8'd2, 6'd60);
		send_beat(ACT_PUSH_BACK, '1, '1, 6'd59);
		while (shadow_held < DEPTH)
			send_beat($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
				TEMPO_W'($urandom_range(511)), MIN_IN_W'($urandom_range(255)),
				SEC_W'($urandom_range(63)));
		send_beat(ACT_PUSH_BACK, '1, '1, '1);
		send_beat(ACT_PUSH_FRONT, '0, '0, '0);
		send_beat(ACT_TALLY, '0, '0, '0);
	endtask

	task automatic test_threshold_extremes();
		set_threshold('0);
		send_beat(ACT_TALLY, '0, '0, '0);
		set_threshold('1);
		send_beat(ACT_TALLY, '0, '0, '0);
		set_threshold(THR_RESET);
		send_beat(ACT_TALLY, '0, '0, '0);
	endtask

	task automatic test_drain_both_ends();
		bit from_front;
		from_front = 1'b1;
		while (shadow_held > 0) begin
			send_beat(from_front ? ACT_POP_FRONT : ACT_POP_BACK, '0, '0, '0);
			from_front = !from_front;
			if (shadow_held == DEPTH / 2)
				send_beat(ACT_TALLY, '0, '0, '0);
		end
		send_beat(ACT_POP_BACK, '0, '0, '0);
		send_beat(ACT_TALLY, '0, '0, '0);
	endtask

	// Each segment picks filling, draining or balanced traffic at random so that the deque
	// keeps reaching both full and empty; two segments run without any idling.
	task automatic test_random_traffic();
		int sent;
		int seg;
		int push_pct;
		sent = 0;
		seg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (seg % 3 == 2) begin
				case ($urandom_range(3))
				0: set_threshold('0);
				1: set_threshold('1);
				2: set_threshold(THR_RESET);
				default: set_threshold(TEMPO_W'($urandom_range(511)));
				endcase
			end
			calm = (seg == 3 || seg == 4);
			case ($urandom_range(2))
			0: push_pct = 80;
			1: push_pct = 20;
			default: push_pct = 50;
			endcase
			repeat (SEGMENT_ITEMS) begin
				send_random_beat(push_pct);
				sent++;
			end
			seg++;
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_threshold_readback();
		test_empty_deque();
		test_fill_to_full();
		test_threshold_extremes();
		test_drain_both_ends();
		test_random_traffic();
		wait_drained();
		$display("Run covered %0d action beats (%0d tallies, %0d refused pushes or pops)",
			beats_sent, tallies_sent, refusals);
		$display("with %0d threshold writes; %0d result beats compared field by field.",
			thr_writes, beats_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("ring_deque_with_duration_tally: match");
		else
			$display("ring_deque_with_duration_tally: mismatch");
		$finish;
	end

endmodule
